@@ hdl/frml_pkg.sv @@
// shared types and constants for the frame rate meter and limiter
// no dependencies; imported by frml_divider and frame_rate_meter_limiter_core
package frml_pkg;

    // field widths fixed by the interface
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned FPS_W   = 22;
    localparam int unsigned DELAY_W = 10;
    localparam int unsigned CAP_W   = 10;

    // register reset value
    localparam logic [CAP_W-1:0] MAX_FPS_RESET = 10'd60;

    // frame period numerator, 1000 ms over the cap
    localparam int unsigned      PERIOD_NUM_W = 10;
    localparam logic [PERIOD_NUM_W-1:0] PERIOD_NUM = 10'd1000;

    // 1000 ms times 256 for the q8 rate
    localparam int unsigned RATE_SCALE   = 256000;
    localparam int unsigned RATE_SCALE_W = 18;

    // rate reported for a zero interval sum, and the field ceiling
    localparam logic [FPS_W-1:0] FPS_ZERO_SUM  = 22'd2560000;
    localparam logic [FPS_W-1:0] FPS_MAX_FIELD = 22'h3FFFFF;

    // divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

@@ hdl/frml_divider.sv @@
// restoring divider, one quotient bit per cycle, shared by the period and rate divisions
// depends on frml_pkg for the status struct
module frml_divider #(
    parameter int unsigned NUM_W = 22,
    parameter int unsigned DEN_W = 36
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [NUM_W-1:0]               i_num,
    input  logic [DEN_W-1:0]               i_den,
    input  logic [$clog2(NUM_W+1)-1:0]     i_iters,
    output logic [NUM_W-1:0]               o_quo,
    output frml_pkg::t_div_stat            o_stat
);
    import frml_pkg::*;

    localparam int unsigned ITER_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0]  r_rem;
    logic [NUM_W-1:0]  r_num;
    logic [DEN_W-1:0]  r_den;
    logic [NUM_W-1:0]  r_quo;
    logic [ITER_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              ge;
    logic [DEN_W-1:0]  n_rem;

    // one trial subtract per cycle
    always_comb begin
        trial = {r_rem, r_num[NUM_W-1]};
        diff  = trial - {1'b0, r_den};
        ge    = (trial >= {1'b0, r_den});
        n_rem = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end

    // control: busy while iterating, done for one cycle after the last bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_iters;
            end else if (r_busy) begin
                r_cnt <= r_cnt - ITER_W'(1);
                if (r_cnt == ITER_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_num <= i_num;
            r_den <= i_den;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_num <= {r_num[NUM_W-2:0], 1'b0};
            r_quo <= {r_quo[NUM_W-2:0], ge};
        end
    end

    assign o_quo       = r_quo;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

@@ hdl/frame_rate_meter_limiter_core.sv @@
// Frame rate meter and limiter. One item per finished frame carries its start and end
// times in ms; the block returns the interval since the previous frame end (zero for the
// first frame after reset), the average rate over the last WINDOW intervals in unsigned
// q8 (2560000 when the held intervals sum to zero, saturated at the 22-bit field) and the
// delay that keeps the rate under max_fps. One shared bit-serial divider does both
// divisions: 1000/max_fps over 10 iterations, then the rate over NUM_W = 18 + count bits
// iterations, skipping the rate division when the interval sum is zero. A finished result
// sits in the output register, so the next item is taken while it waits. max_fps of zero
// acts as one.
// depends on frml_pkg and frml_divider
module frame_rate_meter_limiter_core #(
    parameter int unsigned WINDOW = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [frml_pkg::CAP_W-1:0]    i_cfg_data,
    // input items
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [frml_pkg::TIME_W-1:0]   i_frame_start_ms,
    input  logic [frml_pkg::TIME_W-1:0]   i_frame_end_ms,
    // result items
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [frml_pkg::TIME_W-1:0]   o_interval_ms,
    output logic [frml_pkg::FPS_W-1:0]    o_fps_q8,
    output logic [frml_pkg::DELAY_W-1:0]  o_delay_ms
);
    import frml_pkg::*;

    localparam int unsigned CNT_W  = $clog2(WINDOW + 1);
    localparam int unsigned SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int unsigned SUM_W  = TIME_W + $clog2(WINDOW);
    localparam int unsigned NUM_W  = RATE_SCALE_W + CNT_W;
    localparam int unsigned ITER_W = $clog2(NUM_W + 1);
    localparam int unsigned QX_W   = (NUM_W > FPS_W) ? NUM_W : FPS_W;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SUB  = 6'b000010,
        S_ADD  = 6'b000100,
        S_PDIV = 6'b001000,
        S_FDIV = 6'b010000,
        S_FIN  = 6'b100000
    } t_state;

    t_state              r_state;
    t_state              n_state;
    logic [CAP_W-1:0]    r_max_fps;
    logic [SLOT_W-1:0]   r_slot;
    logic [CNT_W-1:0]    r_count;
    logic [SUM_W-1:0]    r_sum;
    logic [TIME_W-1:0]   r_last_end;
    logic                r_seen;
    logic                r_full;
    logic                r_out_valid;

    logic [TIME_W-1:0]   r_ring [WINDOW];
    logic [TIME_W-1:0]   r_ring_rd;
    logic [TIME_W-1:0]   r_interval;
    logic [TIME_W-1:0]   r_dur;
    logic [DELAY_W-1:0]  r_delay;
    logic [FPS_W-1:0]    r_fps;
    logic [TIME_W-1:0]   r_out_interval;
    logic [FPS_W-1:0]    r_out_fps;
    logic [DELAY_W-1:0]  r_out_delay;

    logic                accept;
    logic                out_load;
    logic [CAP_W-1:0]    cap;
    logic                div_start;
    logic [NUM_W-1:0]    div_num;
    logic [SUM_W-1:0]    div_den;
    logic [ITER_W-1:0]   div_iters;
    logic [NUM_W-1:0]    div_quo;
    t_div_stat           div_stat;
    logic [PERIOD_NUM_W-1:0] period;
    logic [QX_W-1:0]     quo_x;
    logic [FPS_W-1:0]    fps_sat;

    assign accept      = i_valid && o_ready;
    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign out_load    = (r_state == S_FIN) && (!r_out_valid || i_ready);
    assign cap         = (r_max_fps == '0) ? CAP_W'(1) : r_max_fps;
    assign period      = div_quo[PERIOD_NUM_W-1:0];
    assign quo_x       = QX_W'(div_quo);
    assign fps_sat     = (quo_x > QX_W'(FPS_MAX_FIELD)) ? FPS_MAX_FIELD : quo_x[FPS_W-1:0];

    // divider operands: period on accept, rate after the period is back when the interval sum is nonzero
    always_comb begin
        div_start = accept ||
                    ((r_state == S_PDIV) && div_stat.done && (r_sum != '0));
        if (r_state == S_IDLE) begin
            div_num   = NUM_W'(PERIOD_NUM) << (NUM_W - PERIOD_NUM_W);
            div_den   = SUM_W'(cap);
            div_iters = ITER_W'(PERIOD_NUM_W);
        end else begin
            div_num   = NUM_W'(RATE_SCALE) * NUM_W'(r_count);
            div_den   = r_sum;
            div_iters = ITER_W'(NUM_W);
        end
    end

    frml_divider #(
        .NUM_W (NUM_W),
        .DEN_W (SUM_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .i_iters (div_iters),
        .o_quo   (div_quo),
        .o_stat  (div_stat)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (accept) n_state = S_SUB;
            S_SUB:  n_state = S_ADD;
            S_ADD:  n_state = S_PDIV;
            S_PDIV: begin
                if (div_stat.done) n_state = (r_sum == '0) ? S_FIN : S_FDIV;
            end
            S_FDIV: if (div_stat.done) n_state = S_FIN;
            S_FIN:  if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control state and running window bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_max_fps   <= MAX_FPS_RESET;
            r_slot      <= '0;
            r_count     <= '0;
            r_sum       <= '0;
            r_last_end  <= '0;
            r_seen      <= 1'b0;
            r_full      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) r_max_fps <= i_cfg_data;
            if (accept) begin
                r_last_end <= i_frame_end_ms;
                r_seen     <= 1'b1;
                r_full     <= (r_count == CNT_W'(WINDOW));
            end
            // drop the oldest interval once the window is full
            if (r_state == S_SUB) begin
                if (r_full) r_sum <= r_sum - SUM_W'(r_ring_rd);
                else        r_count <= r_count + CNT_W'(1);
                r_slot <= (r_slot == SLOT_W'(WINDOW - 1)) ? '0 : r_slot + SLOT_W'(1);
            end
            if (r_state == S_ADD) r_sum <= r_sum + SUM_W'(r_interval);
            // output register
            if (out_load)     r_out_valid <= 1'b1;
            else if (i_ready) r_out_valid <= 1'b0;
        end
    end

    // interval ring, registered read of the slot about to be replaced
    always_ff @(posedge i_clk) begin
        if (accept) r_ring_rd <= r_ring[r_slot];
        if (r_state == S_SUB) r_ring[r_slot] <= r_interval;
    end

    // item payload and results
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_interval <= r_seen ? (i_frame_end_ms - r_last_end) : '0;
            r_dur      <= i_frame_end_ms - i_frame_start_ms;
        end
        if ((r_state == S_PDIV) && div_stat.done) begin
            r_delay <= (TIME_W'(period) > r_dur) ? (period - r_dur[DELAY_W-1:0]) : '0;
            if (r_sum == '0) r_fps <= FPS_ZERO_SUM;
        end
        if ((r_state == S_FDIV) && div_stat.done) r_fps <= fps_sat;
        if (out_load) begin
            r_out_interval <= r_interval;
            r_out_fps      <= r_fps;
            r_out_delay    <= r_delay;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_interval_ms = r_out_interval;
    assign o_fps_q8      = r_out_fps;
    assign o_delay_ms    = r_out_delay;

    // window bookkeeping stays in range
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(WINDOW))
        else $error("fill count beyond window");

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= SLOT_W'(WINDOW - 1))
        else $error("write slot beyond window");

    // an empty window holds no sum
    a_empty_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_sum == '0))
        else $error("nonzero sum with empty window");

    // an accepted item starts the period division
    a_accept_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (div_stat.busy && (r_state == S_SUB)))
        else $error("divider not started on accept");

endmodule

@@ tb/tb_frame_rate_meter_limiter_core.sv @@
`timescale 1ns / 1ps
// testbench for frame_rate_meter_limiter_core: frames in, interval/rate/delay checked
// against a scoreboard that tracks the window state; depends on frml_pkg and the core
module tb_frame_rate_meter_limiter_core;
    import frml_pkg::*;

    localparam int unsigned WINDOW      = 10;
    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned PHASE_ITEMS = 130;
    localparam int unsigned TAIL_CYCLES = 60;
    localparam int unsigned NUM_PHASES  = 8;
    localparam int unsigned PRESSURE_PHASE = 4;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    typedef struct {
        logic [TIME_W-1:0]  interval;
        logic [FPS_W-1:0]   fps;
        logic [DELAY_W-1:0] delay;
    } t_frame_result;

    logic                 i_clk;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CAP_W-1:0]     i_cfg_data = '0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic [TIME_W-1:0]    i_frame_start_ms = '0;
    logic [TIME_W-1:0]    i_frame_end_ms = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic [TIME_W-1:0]    o_interval_ms;
    logic [FPS_W-1:0]     o_fps_q8;
    logic [DELAY_W-1:0]   o_delay_ms;

    t_idle_mode           idle_mode = IDLE_NONE;
    logic                 rx_hold = 1'b0;
    bit                   pressure_go = 1'b0;
    logic [TIME_W-1:0]    clock_ms;

    frame_rate_meter_limiter_core #(.WINDOW(WINDOW)) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_frame_start_ms (i_frame_start_ms),
        .i_frame_end_ms   (i_frame_end_ms),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_interval_ms    (o_interval_ms),
        .o_fps_q8         (o_fps_q8),
        .o_delay_ms       (o_delay_ms)
    );

    // window state mirror and queue of pending frame results
    class frame_rate_scoreboard;
        bit [TIME_W-1:0]   ring [WINDOW];
        int unsigned       slot;
        int unsigned       filled;
        longint unsigned   sum;
        bit [TIME_W-1:0]   last_end;
        bit                seen_first;
        bit [CAP_W-1:0]    cap;
        t_frame_result     pending_q [$];
        int unsigned       errors;

        function new();
            slot       = 0;
            filled     = 0;
            sum        = 0;
            last_end   = '0;
            seen_first = 1'b0;
            cap        = MAX_FPS_RESET;
            errors     = 0;
        endfunction

        function void set_cap(bit [CAP_W-1:0] value);
            cap = value;
        endfunction

        function int unsigned pending();
            return pending_q.size();
        endfunction

        // advance the window for one accepted frame and queue its result
        function void note_frame(bit [TIME_W-1:0] start_ms, bit [TIME_W-1:0] end_ms);
            bit [TIME_W-1:0]  ivl;
            bit [TIME_W-1:0]  dur;
            bit [TIME_W-1:0]  period;
            int unsigned      cap_eff;
            longint unsigned  rate;
            t_frame_result    res;
            ivl = seen_first ? end_ms - last_end : '0;
            seen_first = 1'b1;
            last_end = end_ms;
            // drop the oldest once the ring is full
            if (filled >= WINDOW)
                sum -= 64'(ring[slot]);
            else
                filled++;
            ring[slot] = ivl;
            sum += 64'(ivl);
            slot = (slot + 1 >= WINDOW) ? 0 : slot + 1;
            // windowed rate in q8
            if (sum == 0) begin
                rate = 64'(FPS_ZERO_SUM);
            end else begin
                rate = (64'(RATE_SCALE) * 64'(filled)) / sum;
                if (rate > 64'(FPS_MAX_FIELD))
                    rate = 64'(FPS_MAX_FIELD);
            end
            // limiter delay, a cap of zero acting as one
            cap_eff = (cap == 0) ? 1 : 32'(cap);
            period = 32'(PERIOD_NUM) / cap_eff;
            dur = end_ms - start_ms;
            res.interval = ivl;
            res.fps = rate[FPS_W-1:0];
            res.delay = (period > dur) ? DELAY_W'(period - dur) : '0;
            pending_q.push_back(res);
        endfunction

        function void check_result(logic [TIME_W-1:0] interval, logic [FPS_W-1:0] fps,
                                   logic [DELAY_W-1:0] delay);
            t_frame_result exp_res;
            if (pending_q.size() == 0) begin
                $display("%0t unexpected result: interval %0d fps %0d delay %0d",
                         $time, interval, fps, delay);
                errors++;
                return;
            end
            exp_res = pending_q.pop_front();
            if (interval !== exp_res.interval) begin
                $display("%0t interval_ms mismatch: expected %0d actual %0d",
                         $time, exp_res.interval, interval);
                errors++;
            end
            if (fps !== exp_res.fps) begin
                $display("%0t fps_q8 mismatch: expected %0d actual %0d",
                         $time, exp_res.fps, fps);
                errors++;
            end
            if (delay !== exp_res.delay) begin
                $display("%0t delay_ms mismatch: expected %0d actual %0d",
                         $time, exp_res.delay, delay);
                errors++;
            end
        endfunction
    endclass

    frame_rate_scoreboard rate_sb = new();

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // result side: check each accepted item, then pick the next ready
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            rate_sb.check_result(o_interval_ms, o_fps_q8, o_delay_ms);
        if (rx_hold)
            i_ready <= 1'b0;
        else if (idle_mode == IDLE_RECEIVER && $urandom_range(99) < 63)
            i_ready <= 1'b0;
        else if (idle_mode == IDLE_BOTH && $urandom_range(99) < 22)
            i_ready <= 1'b0;
        else
            i_ready <= 1'b1;
    end

    // long receiver hold-off so the core backs up into its input
    initial begin
        int unsigned hold_count;
        wait (pressure_go);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        hold_count = 0;
        while (hold_count < HOLD_CYCLES) begin
            @(posedge i_clk);
            hold_count++;
        end
        rx_hold <= 1'b0;
    end

    function automatic bit sender_gap();
        if (idle_mode == IDLE_SENDER)
            return $urandom_range(99) < 63;
        if (idle_mode == IDLE_BOTH)
            return $urandom_range(99) < 22;
        return 1'b0;
    endfunction

    // offer one frame and wait until it is taken
    task automatic send_frame(input logic [TIME_W-1:0] start_ms,
                              input logic [TIME_W-1:0] end_ms);
        while (sender_gap()) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_frame_start_ms <= start_ms;
        i_frame_end_ms <= end_ms;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        rate_sb.note_frame(start_ms, end_ms);
    endtask

    // mostly steady frames on a running clock, some raw noise
    task automatic random_frame(input int unsigned period);
        logic [TIME_W-1:0] ivl;
        logic [TIME_W-1:0] dur;
        logic [TIME_W-1:0] noise_end;
        int unsigned       pick;
        pick = $urandom_range(99);
        if (pick < 15) begin
            noise_end = $urandom;
            clock_ms = noise_end;
            send_frame($urandom, noise_end);
        end else begin
            pick = $urandom_range(99);
            if (pick < 70)
                ivl = $urandom_range(50, 1);
            else if (pick < 80)
                ivl = '0;
            else if (pick < 92)
                ivl = $urandom_range(5000, 51);
            else
                ivl = $urandom;
            pick = $urandom_range(99);
            if (pick < 85)
                dur = $urandom_range(period + 4, 0);
            else
                dur = $urandom;
            clock_ms = clock_ms + ivl;
            send_frame(clock_ms - dur, clock_ms);
        end
    endtask

    // stop offering and wait for every result to come back
    task automatic drain();
        i_valid <= 1'b0;
        while (rate_sb.pending() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_cap(input logic [CAP_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        rate_sb.set_cap(value);
        i_cfg_valid <= 1'b0;
    endtask

    // main sequence
    initial begin
        logic [CAP_W-1:0] cap_list [NUM_PHASES];
        logic [CAP_W-1:0] cap;
        int unsigned      period;
        cap_list = '{10'd1000, 10'd0, 10'd1023, 10'd1, 10'd144, 10'd30, 10'd0, 10'd60};
        cap_list[6] = CAP_W'($urandom_range(1000, 1));
        clock_ms = '0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // first frame, then a zero-sum window that fills and wraps
        send_frame(32'd0, 32'd0);
        repeat (11) send_frame(32'd0, 32'd0);
        // duration equal to the period, then just under it
        send_frame(32'd0, 32'd16);
        send_frame(32'd17, 32'd32);
        // timestamp extremes and wrap of the interval
        send_frame(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_frame(32'hFFFF_FFF0, 32'd5);
        // end before start, maximum and minimum wrapped durations
        send_frame(32'd100, 32'd50);
        send_frame(32'd0, 32'hFFFF_FFFF);
        send_frame(32'hFFFF_FFFF, 32'd0);
        clock_ms = '0;
        drain();

        // random phases, each under its own cap and idling pattern
        for (int p = 0; p < NUM_PHASES; p++) begin
            cap = cap_list[p];
            write_cap(cap);
            period = 1000 / ((cap == 0) ? 1 : 32'(cap));
            idle_mode <= t_idle_mode'(p % 4);
            if (p == PRESSURE_PHASE)
                pressure_go = 1'b1;
            // one frame at the new cap, duration zero gives the full period
            send_frame(clock_ms, clock_ms);
            for (int n = 0; n < PHASE_ITEMS; n++)
                random_frame(period);
            drain();
        end

        idle_mode <= IDLE_NONE;
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (rate_sb.errors == 0 && rate_sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/frml_pkg.sv
hdl/frml_divider.sv
hdl/frame_rate_meter_limiter_core.sv
tb/tb_frame_rate_meter_limiter_core.sv
